/* design/esm_pkg.sv */
// shared types, constants and helpers for the silhouette edge multiplicity block
package esm_pkg;

    // field and datapath widths
    localparam int COORD_W  = 32;               // Q16.16 coordinate
    localparam int DIFF_W   = COORD_W + 1;      // exact difference of two points
    localparam int VTERM_W  = 64;               // light term in Q32.32
    localparam int CROSS_W  = 98;               // one exact cross product component
    localparam int ACC_W    = 136;              // holds the exact dot product
    localparam int LIMB_W   = 32;               // chunk width fed to the multiplier
    localparam int MUL_W    = LIMB_W + 1;       // signed multiplier operand width
    localparam int PROD_W   = 2 * MUL_W;        // multiplier result width
    localparam int LSHIFT   = 16;               // light xyz scale to Q32.32

    // per-edge bookkeeping
    localparam int MAX_OPPOSITES = 16;
    localparam int CNT_W         = $clog2(MAX_OPPOSITES + 1);
    localparam int SUM_W         = 6;
    localparam int SUM_MAX       = 16;
    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'(SUM_MAX);
    localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_W = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [VTERM_W-1:0] vterm_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [MUL_W-1:0]   mul_op_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VTERM,
        ST_CROSS,
        ST_DOT,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // one multiply-accumulate step travelling from the multiplier to the accumulator
    typedef struct packed {
        logic       valid;
        logic [1:0] shift;       // limb position of the partial product
        logic       sub;         // subtract instead of add
        logic       first;       // start a new sum
        logic       init_light;  // new sum starts at the scaled light coordinate
        logic       wr_v;        // store finished light term
        logic       wr_n;        // store finished cross component
        logic [1:0] k;           // component index
    } mac_op_t;

    // lexicographic a > b, x first, then y, then z
    function automatic logic lex_greater(input point_t a, input point_t b);
        logic gx, gy, gz, ex, ey;
        gx = $signed(a.x) > $signed(b.x);
        gy = $signed(a.y) > $signed(b.y);
        gz = $signed(a.z) > $signed(b.z);
        ex = a.x == b.x;
        ey = a.y == b.y;
        return gx | (ex & (gy | (ey & gz)));
    endfunction

    // exact difference a - b
    function automatic diff_t sub_exact(input coord_t a, input coord_t b);
        return diff_t'($signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b}));
    endfunction

endpackage

/* design/edge_silhouette_multiplicity_top.sv */
// silhouette edge multiplicity: ordering, exact orientation sign and per-edge sum
// One beat on the s_ channel is one (edge, opposite vertex) pair. The block orders the
// three points, then runs the exact orientation test against the light on a single
// 33x33 signed multiplier followed by a 136-bit accumulator, one partial product per
// cycle: 3 steps for the light terms, 12 for the cross product and 12 for the dot
// product. A beat therefore occupies the block from acceptance to the next s_ready; once
// an edge has taken MAX_OPPOSITES (16) opposites, further beats of that edge skip the
// arithmetic and go straight to the finish state. s_ready is high only while the
// sequencer is idle. The beat with s_last_opposite set produces one m_ beat carrying
// the clamped sum; that result sits in an output register, and the block only waits
// on m_ready if an earlier result is still untaken when the next sum is due. The
// light position is written over the cfg_ channel, which is always ready, and must
// only be changed between beats.
module edge_silhouette_multiplicity_top
    import esm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [COORD_W-1:0] s_low_x,
    input  logic signed [COORD_W-1:0] s_low_y,
    input  logic signed [COORD_W-1:0] s_low_z,
    input  logic signed [COORD_W-1:0] s_high_x,
    input  logic signed [COORD_W-1:0] s_high_y,
    input  logic signed [COORD_W-1:0] s_high_z,
    input  logic signed [COORD_W-1:0] s_opp_x,
    input  logic signed [COORD_W-1:0] s_opp_y,
    input  logic signed [COORD_W-1:0] s_opp_z,
    input  logic                 s_last_opposite,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [SUM_W-1:0] m_multiplicity
);

    // light registers
    coord_t light_reg [3];
    coord_t light_w_reg;

    // sequencer
    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] k_plus, k_minus;

    // per-beat operands
    coord_t pa_reg [3];
    diff_t  u_reg [3];
    diff_t  e_reg [3];
    vterm_t v_reg [3];
    cross_t n_reg [3];
    logic   last_reg;
    logic   neg_reg;

    // multiplier stage and accumulator
    mul_op_t mul_a, mul_b;
    prod_t   pp_reg;
    mac_op_t op_reg, op_next;
    acc_t    acc_reg;
    acc_t    acc_base, acc_term, acc_sum, pp_ext, light_init;
    diff_t   ux;
    vterm_t  vw;
    cross_t  nw;

    // edge bookkeeping and result
    logic [CNT_W-1:0]       count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                   m_valid_reg, m_valid_next;
    logic signed [SUM_W-1:0] m_mult_reg;
    logic                   fin_stall;
    logic                   below_max;
    logic signed [1:0]      step;
    logic signed [SUM_W:0]  sum_wide, sum_clamped;

    // input ordering
    point_t pt_low, pt_high, pt_opp;
    point_t ord_a, ord_b, ord_c;
    logic   ord_neg;
    logic   s_accept;

    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_multiplicity = m_mult_reg;
    assign s_accept       = s_valid & s_ready;
    assign below_max      = count_reg < CNT_W'(MAX_OPPOSITES);
    assign fin_stall      = last_reg & m_valid_reg & ~m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg[0] <= '0;
            light_reg[1] <= '0;
            light_reg[2] <= '0;
            light_w_reg  <= COORD_W'(32'sd65536);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LIGHT_X: light_reg[0] <= cfg_data;
                CFG_LIGHT_Y: light_reg[1] <= cfg_data;
                CFG_LIGHT_Z: light_reg[2] <= cfg_data;
                CFG_LIGHT_W: light_w_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // order the three points and pick the sign flip
    always_comb begin
        pt_low  = '{x: s_low_x,  y: s_low_y,  z: s_low_z};
        pt_high = '{x: s_high_x, y: s_high_y, z: s_high_z};
        pt_opp  = '{x: s_opp_x,  y: s_opp_y,  z: s_opp_z};
        if (lex_greater(pt_low, pt_opp)) begin
            ord_a   = pt_opp;
            ord_b   = pt_low;
            ord_c   = pt_high;
            ord_neg = 1'b0;
        end else if (lex_greater(pt_high, pt_opp)) begin
            ord_a   = pt_low;
            ord_b   = pt_opp;
            ord_c   = pt_high;
            ord_neg = 1'b1;
        end else begin
            ord_a   = pt_low;
            ord_b   = pt_high;
            ord_c   = pt_opp;
            ord_neg = 1'b0;
        end
    end

    // capture ordered point and edge differences
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pa_reg[0] <= ord_a.x;
            pa_reg[1] <= ord_a.y;
            pa_reg[2] <= ord_a.z;
            u_reg[0]  <= sub_exact(ord_c.x, ord_a.x);
            u_reg[1]  <= sub_exact(ord_c.y, ord_a.y);
            u_reg[2]  <= sub_exact(ord_c.z, ord_a.z);
            e_reg[0]  <= sub_exact(ord_b.x, ord_a.x);
            e_reg[1]  <= sub_exact(ord_b.y, ord_a.y);
            e_reg[2]  <= sub_exact(ord_b.z, ord_a.z);
            last_reg  <= s_last_opposite;
            neg_reg   <= ord_neg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = below_max ? ST_VTERM : ST_FINISH;
                end
            end
            ST_VTERM: begin
                if (k_reg == 2'd2) begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS: begin
                if (j_reg == 2'd3 && k_reg == 2'd0) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (j_reg == 2'd3 && k_reg == 2'd0) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!fin_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // neighbor component indexes, k+1 and k+2 modulo three
    assign k_plus  = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
    assign k_minus = (k_reg == 2'd0) ? 2'd2 : k_reg - 2'd1;

    // sequencer outputs: counters, handshake and multiplier operands
    always_comb begin
        s_ready = 1'b0;
        k_next  = k_reg;
        j_next  = j_reg;
        mul_a   = '0;
        mul_b   = '0;
        op_next = '0;
        ux      = j_reg[1] ? u_reg[k_minus] : u_reg[k_plus];
        vw      = j_reg[1] ? v_reg[k_plus] : v_reg[k_minus];
        nw      = n_reg[k_reg];
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                k_next  = 2'd0;
                j_next  = 2'd0;
            end
            // light term: L.xyz * 2^16 - A * L.w
            ST_VTERM: begin
                mul_a              = {pa_reg[k_reg][COORD_W-1], pa_reg[k_reg]};
                mul_b              = {light_w_reg[COORD_W-1], light_w_reg};
                op_next.valid      = 1'b1;
                op_next.sub        = 1'b1;
                op_next.first      = 1'b1;
                op_next.init_light = 1'b1;
                op_next.wr_v       = 1'b1;
                op_next.k          = k_reg;
                k_next             = (k_reg == 2'd2) ? 2'd2 : k_reg + 2'd1;
            end
            // cross component k = u[k+1]*v[k+2] - u[k+2]*v[k+1], one limb of v a step
            ST_CROSS: begin
                mul_a         = ux;
                mul_b         = j_reg[0] ? {vw[VTERM_W-1], vw[VTERM_W-1:LIMB_W]}
                                         : {1'b0, vw[LIMB_W-1:0]};
                op_next.valid = 1'b1;
                op_next.shift = {1'b0, j_reg[0]};
                op_next.sub   = j_reg[1];
                op_next.first = j_reg == 2'd0;
                op_next.wr_n  = j_reg == 2'd3;
                op_next.k     = k_reg;
                j_next        = j_reg + 2'd1;
                if (j_reg == 2'd3) begin
                    k_next = k_minus;
                end
            end
            // dot product, one limb of the cross component a step
            ST_DOT: begin
                mul_a = e_reg[k_reg];
                case (j_reg)
                    2'd0: mul_b = {1'b0, nw[LIMB_W-1:0]};
                    2'd1: mul_b = {1'b0, nw[2*LIMB_W-1:LIMB_W]};
                    2'd2: mul_b = {1'b0, nw[3*LIMB_W-1:2*LIMB_W]};
                    default: mul_b = {{(MUL_W-(CROSS_W-3*LIMB_W)){nw[CROSS_W-1]}},
                                      nw[CROSS_W-1:3*LIMB_W]};
                endcase
                op_next.valid = 1'b1;
                op_next.shift = j_reg;
                op_next.first = (k_reg == 2'd2) && (j_reg == 2'd0);
                op_next.k     = k_reg;
                j_next        = j_reg + 2'd1;
                if (j_reg == 2'd3) begin
                    k_next = k_minus;
                end
            end
            default: ;
        endcase
    end

    // multiplier stage
    always_ff @(posedge aclk) begin
        pp_reg <= mul_a * mul_b;
    end

    // accumulator stage
    always_comb begin
        pp_ext     = {{(ACC_W-PROD_W){pp_reg[PROD_W-1]}}, pp_reg};
        light_init = {{(ACC_W-COORD_W-LSHIFT){light_reg[op_reg.k][COORD_W-1]}},
                      light_reg[op_reg.k], {LSHIFT{1'b0}}};
        case (op_reg.shift)
            2'd0: acc_term = pp_ext;
            2'd1: acc_term = pp_ext << LIMB_W;
            2'd2: acc_term = pp_ext << (2 * LIMB_W);
            default: acc_term = pp_ext << (3 * LIMB_W);
        endcase
        if (op_reg.first) begin
            acc_base = op_reg.init_light ? light_init : '0;
        end else begin
            acc_base = acc_reg;
        end
        acc_sum = op_reg.sub ? acc_base - acc_term : acc_base + acc_term;
    end

    always_ff @(posedge aclk) begin
        if (op_reg.valid) begin
            acc_reg <= acc_sum;
            if (op_reg.wr_v) begin
                v_reg[op_reg.k] <= acc_sum[VTERM_W-1:0];
            end
            if (op_reg.wr_n) begin
                n_reg[op_reg.k] <= acc_sum[CROSS_W-1:0];
            end
        end
    end

    // sign of the dot product, flipped for the middle ordering, added with clamp
    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            step = -2'sd1;
        end else if (|acc_reg) begin
            step = 2'sd1;
        end else begin
            step = 2'sd0;
        end
        if (neg_reg) begin
            step = -step;
        end
        sum_wide = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W-1){step[1]}}, step};
        if (sum_wide > SUM_HI) begin
            sum_clamped = SUM_HI;
        end else if (sum_wide < SUM_LO) begin
            sum_clamped = SUM_LO;
        end else begin
            sum_clamped = sum_wide;
        end
    end

    // edge bookkeeping and output register
    always_comb begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (state_reg == ST_FINISH && !fin_stall) begin
            if (below_max) begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_clamped[SUM_W-1:0];
            end
            if (last_reg) begin
                count_next   = '0;
                sum_next     = '0;
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && !fin_stall && last_reg) begin
            m_mult_reg <= below_max ? sum_clamped[SUM_W-1:0] : sum_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            j_reg       <= '0;
            op_reg      <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            op_reg      <= op_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a beat below the opposite limit starts the arithmetic, one at the limit skips it
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == (($past(below_max)) ? ST_VTERM : ST_FINISH)))
        else $error("sequencer did not start as expected after a beat");

    // a result appears only from the finish step of a last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH && last_reg))
        else $error("result raised outside a finishing last beat");

    // opposite count stays within the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_OPPOSITES))
        else $error("opposite count beyond limit");

    // running sum stays inside the clamp range
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($signed({sum_reg[SUM_W-1], sum_reg}) <= SUM_HI) &&
        ($signed({sum_reg[SUM_W-1], sum_reg}) >= SUM_LO))
        else $error("running sum out of range");

endmodule
